### rtl/frustum_cull_test_defines.svh
// Assertion macros shared by the frustum cull checker.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define FCT_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising clock edge that also runs through reset.
`define FCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fct_pkg.sv
// Shared types, widths and helper functions of the frustum cull block.
`default_nettype none

package fct_pkg;

  // Fixed-point format of coordinates and matrix elements.
  localparam int FRAC_BITS = 16;

  // Geometry.
  localparam int NPLANES    = 6;
  localparam int NCOMP      = 4;
  localparam int NAXES      = 3;
  localparam int OFFSET_COL = 3;

  // Datapath widths. Coefficients are a sum of two 32-bit elements.
  localparam int CW  = 32;
  localparam int NW  = CW + 1;
  localparam int PW  = NW + CW;
  localparam int VW  = PW + 1;
  localparam int HW  = VW / 2;
  localparam int SQW = 2 * NW - 1;
  localparam int NNW = SQW + 1;
  localparam int NNH = NNW / 2;
  localparam int RW  = 31;
  localparam int R2W = 2 * RW;
  localparam int R2H = R2W / 2;
  localparam int RPW = R2H + NNH;
  localparam int LPW = 2 * HW;
  localparam int LW  = 2 * VW;

  // Pipeline depth from input register to output register.
  localparam int NSTAGES = 9;

  // Configuration port.
  localparam int DW       = 64;
  localparam int HALF_W   = DW / 2;
  localparam int NREGS    = 8;
  localparam int IW       = $clog2(NREGS);
  localparam int ADDR_LSB = $clog2(DW / 8);
  localparam int AW       = IW + ADDR_LSB;

  typedef logic signed [NW-1:0] coef_t;
  typedef logic signed [CW-1:0] coord_t;

  // Shape codes.
  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2,
    OP_NONE   = 2'd3
  } fct_op_t;

  // Stage load enables handed from the pipeline control to each plane.
  typedef struct packed {
    logic ld_pick;
    logic ld_prod;
    logic ld_sum;
    logic ld_abs;
    logic ld_part;
    logic ld_lsum;
    logic ld_flag;
  } fct_ctrl_t;

  // Per-plane outcome: value negative, value not positive, sphere culled.
  typedef struct packed {
    logic neg;
    logic le0;
    logic sph;
  } fct_pres_t;

  // Register that holds matrix element M[row][col].
  function automatic logic [IW-1:0] mat_reg(input int col, input int row);
    int idx;
    idx = 2 * col + (row >> 1);
    return idx[IW-1:0];
  endfunction

  // Element of a register for a given row, sign-extended to coefficient width.
  function automatic coef_t mat_elem(input logic [DW-1:0] r, input int row);
    logic [HALF_W-1:0] h;
    h = row[0] ? r[DW-1:HALF_W] : r[HALF_W-1:0];
    return coef_t'(signed'(h));
  endfunction

endpackage

`default_nettype wire

### rtl/fct_item_if.sv
// Input channel carrying one shape per transfer.
`default_nettype none

interface fct_item_if;
  import fct_pkg::*;

  logic         valid;
  logic         ready;
  logic [1:0]   op;
  coord_t       x_a;
  coord_t       y_a;
  coord_t       z_a;
  coord_t       x_b;
  coord_t       y_b;
  coord_t       z_b;
  logic [RW-1:0] radius;

  modport source (
    output valid, op, x_a, y_a, z_a, x_b, y_b, z_b, radius,
    input  ready
  );

  modport sink (
    input  valid, op, x_a, y_a, z_a, x_b, y_b, z_b, radius,
    output ready
  );
endinterface

`default_nettype wire

### rtl/fct_res_if.sv
// Result channel carrying one visibility flag per transfer.
`default_nettype none

interface fct_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (
    output valid, visible,
    input  ready
  );

  modport sink (
    input  valid, visible,
    output ready
  );
endinterface

`default_nettype wire

### rtl/fct_plane.sv
// Datapath of one clip plane: plane value, point, box and sphere tests.
`default_nettype none

module fct_plane (
  input  logic               clk,
  input  fct_pkg::fct_ctrl_t ctrl,
  input  fct_pkg::coef_t     ncoef [fct_pkg::NCOMP],
  input  fct_pkg::coord_t    coord_a [fct_pkg::NAXES],
  input  fct_pkg::coord_t    coord_b [fct_pkg::NAXES],
  input  logic               box,
  input  logic [fct_pkg::R2W-1:0] r2,
  output fct_pkg::fct_pres_t res
);
  import fct_pkg::*;

  // Coefficient chain, free running: n_q, sq_q and nn_q register in turn
  // after a register write.
  coef_t               n_q [NCOMP];
  logic signed [2*NW-1:0] sq_full [NAXES];
  logic [SQW-1:0]      sq_q [NAXES];
  logic [NNW-1:0]      nn_q;

  // Item stages.
  coord_t              sel [NAXES];
  logic signed [PW-1:0] prod [NAXES];
  logic signed [VW-1:0] off;
  logic signed [VW-1:0] v;
  logic                neg5, le5;
  logic [VW-1:0]       av;
  logic [RPW-1:0]      rp_hh, rp_hl, rp_lh, rp_ll;
  logic                neg6, le6;
  logic [LPW-1:0]      lp_hh, lp_hl, lp_ll;
  logic [LW-1:0]       rhs6;
  logic                neg7, le7;
  logic [LW-1:0]       lhs7, rhs7;

  // Squares of the normal components.
  always_comb begin
    for (int k = 0; k < NAXES; k++) begin
      sq_full[k] = n_q[k] * n_q[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NCOMP; k++) begin
      n_q[k] <= ncoef[k];
    end
    for (int k = 0; k < NAXES; k++) begin
      sq_q[k] <= sq_full[k][SQW-1:0];
    end
    nn_q <= NNW'(sq_q[0]) + NNW'(sq_q[1]) + NNW'(sq_q[2]);
  end

  // Offset term D scaled into the product format.
  assign off = VW'(n_q[NCOMP-1]) <<< FRAC_BITS;

  // Coordinate choice: the box takes the corner farthest along the normal.
  always_ff @(posedge clk) begin
    if (ctrl.ld_pick) begin
      for (int k = 0; k < NAXES; k++) begin
        if (!box) begin
          sel[k] <= coord_a[k];
        end else if (!ncoef[k][NW-1]) begin
          sel[k] <= (coord_a[k] > coord_b[k]) ? coord_a[k] : coord_b[k];
        end else begin
          sel[k] <= (coord_a[k] < coord_b[k]) ? coord_a[k] : coord_b[k];
        end
      end
    end
  end

  // Per-axis products.
  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      for (int k = 0; k < NAXES; k++) begin
        prod[k] <= n_q[k] * sel[k];
      end
    end
  end

  // Plane value.
  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      v <= VW'(prod[0]) + VW'(prod[1]) + VW'(prod[2]) + off;
    end
  end

  // Sign flags, magnitude and partial products of r^2 * (n.n).
  always_ff @(posedge clk) begin
    if (ctrl.ld_abs) begin
      neg5  <= v[VW-1];
      le5   <= v[VW-1] || (v == '0);
      av    <= v[VW-1] ? VW'(-v) : VW'(v);
      rp_hh <= r2[R2W-1:R2H] * nn_q[NNW-1:NNH];
      rp_hl <= r2[R2W-1:R2H] * nn_q[NNH-1:0];
      rp_lh <= r2[R2H-1:0] * nn_q[NNW-1:NNH];
      rp_ll <= r2[R2H-1:0] * nn_q[NNH-1:0];
    end
  end

  // Partial products of |v|^2 and the assembled right-hand side.
  always_ff @(posedge clk) begin
    if (ctrl.ld_part) begin
      neg6  <= neg5;
      le6   <= le5;
      lp_hh <= av[VW-1:HW] * av[VW-1:HW];
      lp_hl <= av[VW-1:HW] * av[HW-1:0];
      lp_ll <= av[HW-1:0] * av[HW-1:0];
      rhs6  <= (LW'(rp_hh) << (R2H + NNH)) + (LW'(rp_hl) << R2H)
             + (LW'(rp_lh) << NNH) + LW'(rp_ll);
    end
  end

  // Left-hand side assembled.
  always_ff @(posedge clk) begin
    if (ctrl.ld_lsum) begin
      neg7 <= neg6;
      le7  <= le6;
      rhs7 <= rhs6;
      lhs7 <= (LW'(lp_hh) << (2 * HW)) + (LW'(lp_hl) << (HW + 1)) + LW'(lp_ll);
    end
  end

  // Plane outcome; the sphere is culled when v <= 0 and v^2 >= r^2 (n.n).
  always_ff @(posedge clk) begin
    if (ctrl.ld_flag) begin
      res.neg <= neg7;
      res.le0 <= le7;
      res.sph <= le7 && (lhs7 >= rhs7);
    end
  end

endmodule

`default_nettype wire

### rtl/frustum_cull_test.sv
// Top level of the six-plane frustum cull test for points, spheres and boxes.
// Throughput: one shape per cycle unless the result stalls; the depth is set by
// the sphere test's split wide multiplies, and stalls back up stage by stage
// without loss. Reset (synchronous) empties the pipeline and clears the clip
// matrix; plane coefficients follow the registers through free-running stages.
`default_nettype none

module frustum_cull_test (
  input  logic                     clk,
  input  logic                     rst,
  fct_item_if.sink                 item,
  fct_res_if.source                result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [fct_pkg::AW-1:0]   paddr,
  input  logic [fct_pkg::DW-1:0]   pwdata,
  output logic [fct_pkg::DW-1:0]   prdata,
  output logic                     pready
);
  import fct_pkg::*;

  logic [DW-1:0]      clip_reg [NREGS];
  logic               wr;

  logic [NSTAGES:1]   vld;
  logic [NSTAGES:1]   rdy;
  fct_ctrl_t          ctrl;

  fct_op_t            op_q [1:NSTAGES-1];
  coord_t             ca1 [NAXES];
  coord_t             cb1 [NAXES];
  logic [RW-1:0]      rad1;
  logic [R2W-1:0]     r2_c;
  logic [R2W-1:0]     r2_q [2:4];

  fct_pres_t          pres [NPLANES];
  logic               any_neg, any_le0, any_sph;
  logic               vis_next;
  logic               vis;

  // Configuration registers; a write lands at the access phase.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign prdata = clip_reg[paddr[AW-1:ADDR_LSB]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREGS; i++) begin
        clip_reg[i] <= '0;
      end
    end else if (wr) begin
      clip_reg[paddr[AW-1:ADDR_LSB]] <= pwdata;
    end
  end

  // Handshake: a stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[NSTAGES] = !vld[NSTAGES] || result.ready;
    for (int k = NSTAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign item.ready   = rdy[1];
  assign result.valid = vld[NSTAGES];
  assign result.visible = vis;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= item.valid;
      end
      for (int k = 2; k <= NSTAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign ctrl.ld_pick = rdy[2];
  assign ctrl.ld_prod = rdy[3];
  assign ctrl.ld_sum  = rdy[4];
  assign ctrl.ld_abs  = rdy[5];
  assign ctrl.ld_part = rdy[6];
  assign ctrl.ld_lsum = rdy[7];
  assign ctrl.ld_flag = rdy[8];

  // Input register.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ca1[0]  <= item.x_a;
      ca1[1]  <= item.y_a;
      ca1[2]  <= item.z_a;
      cb1[0]  <= item.x_b;
      cb1[1]  <= item.y_b;
      cb1[2]  <= item.z_b;
      rad1    <= item.radius;
    end
  end

  // Shape code and squared radius travel with the item.
  assign r2_c = rad1 * rad1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op_q[1] <= fct_op_t'(item.op);
    end
    for (int k = 2; k < NSTAGES; k++) begin
      if (rdy[k]) begin
        op_q[k] <= op_q[k-1];
      end
    end
    if (rdy[2]) begin
      r2_q[2] <= r2_c;
    end
    for (int k = 3; k <= 4; k++) begin
      if (rdy[k]) begin
        r2_q[k] <= r2_q[k-1];
      end
    end
  end

  // Planes: column 3 minus, then plus, column j of the clip matrix.
  for (genvar p = 0; p < NPLANES; p++) begin : g_plane
    localparam int J = p >> 1;
    coef_t ncoef [NCOMP];

    for (genvar k = 0; k < NCOMP; k++) begin : g_comp
      coef_t m3, mj;
      assign m3 = mat_elem(clip_reg[mat_reg(OFFSET_COL, k)], k);
      assign mj = mat_elem(clip_reg[mat_reg(J, k)], k);
      assign ncoef[k] = (p % 2 == 1) ? m3 + mj : m3 - mj;
    end

    fct_plane u_plane (
      .clk     (clk),
      .ctrl    (ctrl),
      .ncoef   (ncoef),
      .coord_a (ca1),
      .coord_b (cb1),
      .box     (op_q[1] == OP_BOX),
      .r2      (r2_q[4]),
      .res     (pres[p])
    );
  end

  // Reduce the plane outcomes and pick the rule of the shape.
  always_comb begin
    any_neg = 1'b0;
    any_le0 = 1'b0;
    any_sph = 1'b0;
    for (int p = 0; p < NPLANES; p++) begin
      any_neg = any_neg || pres[p].neg;
      any_le0 = any_le0 || pres[p].le0;
      any_sph = any_sph || pres[p].sph;
    end
    unique case (op_q[NSTAGES-1])
      OP_POINT:  vis_next = !any_neg;
      OP_SPHERE: vis_next = !any_sph;
      OP_BOX:    vis_next = !any_le0;
      OP_NONE:   vis_next = 1'b1;
      default:   vis_next = 1'b1;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy[NSTAGES]) begin
      vis <= vis_next;
    end
  end

endmodule

`default_nettype wire

### rtl/fct_checker.sv
// Port-level checks of the frustum cull block and their binding.
`default_nettype none
`include "frustum_cull_test_defines.svh"

module fct_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic                   res_visible,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [fct_pkg::AW-1:0] paddr,
  input logic [fct_pkg::DW-1:0] pwdata,
  input logic [fct_pkg::DW-1:0] prdata
);
  import fct_pkg::*;

  // A stalled result holds until its transfer.
  `FCT_ASSERT_RST(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_visible), "result changed while stalled")

  // Input back-pressure only comes from a full pipeline behind a stalled result.
  `FCT_ASSERT_RST(a_ready_full, clk, rst, !in_ready |-> res_valid && !res_ready, "input stalled without a stalled result")

  // Reset leaves no result pending.
  `FCT_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !res_valid, "result valid after reset")

  // A register read right after a write to it returns the written data.
  `FCT_ASSERT_RST(a_readback, clk, rst, psel && !pwrite && !$past(rst) && $past(psel && penable && pwrite) && paddr == $past(paddr) |-> prdata == $past(pwdata), "register readback mismatch")

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (item.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_visible (result.visible),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire
